// ===== rtl/core/fsp_pkg.sv =====
// Shared types, widths and codes of the fixed slot pool allocator.
package fsp_pkg;

  // Field widths
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned SIZE_W    = 16;
  localparam int unsigned COUNT_W   = 9;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // Default pool capacity
  localparam int unsigned MAX_SLOTS_DEF = 256;

  // Register reset values
  localparam logic [ADDR_W-1:0]  BASE_RST  = 32'd0;
  localparam logic [SIZE_W-1:0]  SIZE_RST  = 16'd16;
  localparam logic [COUNT_W-1:0] COUNT_RST = 9'd256;

  // Item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_INIT  = 2'd0,
    KIND_ALLOC = 2'd1,
    KIND_FREE  = 2'd2,
    KIND_QUERY = 2'd3
  } kind_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE  = 2'd0,
    CFG_SIZE  = 2'd1,
    CFG_COUNT = 2'd2
  } cfg_index_e;

  // Result of the serial divider
  typedef struct packed {
    logic              done;
    logic [ADDR_W-1:0] quot;
    logic [SIZE_W-1:0] rem;
  } div_res_t;

endpackage

// ===== rtl/core/fsp_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module fsp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/fsp_div.sv =====
// Bit-serial restoring divider: 32-bit dividend by 16-bit divisor, one bit a cycle.
module fsp_div
  import fsp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [ADDR_W-1:0] dividend_i,
  input  logic [SIZE_W-1:0] divisor_i,
  output div_res_t          res_o
);

  localparam int unsigned STEPS = ADDR_W;
  localparam int unsigned CW    = $clog2(STEPS + 1);

  logic [ADDR_W-1:0] num_q, num_d;
  logic [SIZE_W-1:0] rem_q, rem_d;
  logic [SIZE_W-1:0] den_q;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [SIZE_W:0]   trial;
  logic [SIZE_W:0]   diff;

  // One quotient bit per step; quotient bits shift into the dividend register
  assign trial = {rem_q, num_q[ADDR_W-1]};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d = dividend_i;
      rem_d = '0;
      cnt_d = CW'(STEPS);
    end else if (cnt_q != '0) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = diff[SIZE_W-1:0];
        num_d = {num_q[ADDR_W-2:0], 1'b1};
      end else begin
        rem_d = trial[SIZE_W-1:0];
        num_d = {num_q[ADDR_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= divisor_i;
    end
  end

  assign res_o.done = done_q;
  assign res_o.quot = num_q;
  assign res_o.rem  = rem_q;

endmodule

// ===== rtl/core/fsp_mul.sv =====
// Bit-serial shift-add multiplier: slot index times slot size, index bit per cycle.
module fsp_mul
  import fsp_pkg::*;
#(
  parameter int unsigned A_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [A_W-1:0]    a_i,
  input  logic [SIZE_W-1:0] b_i,
  output logic              done_o,
  output logic [ADDR_W-1:0] prod_o
);

  localparam int unsigned CW = $clog2(A_W + 1);

  logic [A_W-1:0]    a_q, a_d;
  logic [SIZE_W-1:0] b_q;
  logic [ADDR_W-1:0] prod_q, prod_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              done_q, done_d;

  // MSB first: prod = 2*prod + (bit ? b : 0), kept modulo 2^32
  always_comb begin
    a_d    = a_q;
    prod_d = prod_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d    = a_i;
      prod_d = '0;
      cnt_d  = CW'(A_W);
    end else if (cnt_q != '0) begin
      if (a_q[A_W-1]) begin
        prod_d = {prod_q[ADDR_W-2:0], 1'b0} + {{(ADDR_W-SIZE_W){1'b0}}, b_q};
      end else begin
        prod_d = {prod_q[ADDR_W-2:0], 1'b0};
      end
      a_d   = a_q << 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    prod_q <= prod_d;
    if (start_i) begin
      b_q <= b_i;
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

// ===== rtl/core/fixed_slot_pool_allocator_top.sv =====
// Top level of the fixed slot pool allocator: control sequencer, state and memories.
//
// Usage: items enter on the in channel (in_valid_i / in_ready_o) with a kind and
// an address; one result item per input item leaves on the out channel
// (out_valid_o / out_ready_i). Registers base_address, slot_size and slot_count
// are written through the cfg channel (index 0, 1, 2; index 3 is ignored) while
// the block is idle; cfg_ready_o is always high.
// Steps per item: init and a refused alloc go straight to the result; alloc of a
//   fresh slot runs the bit-serial multiplier (index times size), of a freed slot
//   first reads the stack memory; free and query run the bit-serial divider that
//   turns the address into a slot index (32 steps), and a member address then
//   reads its slot flag.
// One item is worked on at a time.
// The next item is taken while a finished result still waits in the output
// register; if the receiver stalls, the following result holds in the block
// and no further item is taken until the output register frees up.
// Reset puts the pool in the just-initialised state with the register reset
// values; the stacks need no clearing pass since the slot flags are qualified
// by the count of slots handed out since init.
module fixed_slot_pool_allocator_top
  import fsp_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ADDR_W-1:0]    cfg_data_i,
  // input item channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [KIND_W-1:0]    kind_i,
  input  logic [ADDR_W-1:0]    address_i,
  // result item channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [ADDR_W-1:0]    slot_address_o,
  output logic                 success_o,
  output logic                 is_member_o,
  output logic                 is_allocated_o,
  output logic [COUNT_W-1:0]   in_use_count_o,
  output logic                 pool_full_o,
  output logic                 pool_empty_o
);

  localparam int unsigned IDX_W = $clog2(MAX_SLOTS);
  localparam int unsigned CNT_W = $clog2(MAX_SLOTS + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_POP  = 7'b0000010,
    S_MUL  = 7'b0000100,
    S_DIV  = 7'b0001000,
    S_RDA  = 7'b0010000,
    S_DONE = 7'b0100000,
    S_SPARE = 7'b1000000
  } state_e;

  state_e             state_q, state_d;
  kind_e              kind_q, kind_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               pre_ok_q, pre_ok_d;

  // configuration registers
  logic [ADDR_W-1:0]  base_q;
  logic [SIZE_W-1:0]  size_q;
  logic [COUNT_W-1:0] count_q;

  // pool state
  logic [CNT_W-1:0]   stack_depth_q, stack_depth_d;
  logic [CNT_W-1:0]   fresh_next_q, fresh_next_d;
  logic [COUNT_W-1:0] used_q, used_d;

  // pending result
  logic [ADDR_W-1:0]  res_addr_q, res_addr_d;
  logic               res_ok_q, res_ok_d;
  logic               res_mem_q, res_mem_d;
  logic               res_alc_q, res_alc_d;

  // output register
  logic               out_valid_q, out_valid_d;
  logic               out_load;
  logic [ADDR_W-1:0]  out_addr_q;
  logic               out_ok_q, out_mem_q, out_alc_q;
  logic [COUNT_W-1:0] out_used_q;
  logic               out_full_q, out_empty_q;

  // unit and memory controls
  logic [CNT_W-1:0]   eff_n;
  logic [CNT_W-1:0]   stk_top;
  logic               div_start;
  div_res_t           div_res;
  logic               mul_start;
  logic [IDX_W-1:0]   mul_a;
  logic               mul_done;
  logic [ADDR_W-1:0]  mul_prod;
  logic               stk_we, stk_re;
  logic [IDX_W-1:0]   stk_raddr, stk_rdata;
  logic               alc_we, alc_wdata, alc_re, alc_rdata;
  logic               alc_hit;

  // Effective slot count, capped at the pool capacity
  always_comb begin
    if (32'(count_q) > MAX_SLOTS) begin
      eff_n = CNT_W'(MAX_SLOTS);
    end else begin
      eff_n = CNT_W'(count_q);
    end
  end

  assign stk_top   = stack_depth_q - 1'b1;
  assign stk_raddr = stk_top[IDX_W-1:0];

  // Slot flag counts only for slots handed out since init
  assign alc_hit = (CNT_W'(idx_q) < fresh_next_q) && alc_rdata;

  // Configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= BASE_RST;
      size_q  <= SIZE_RST;
      count_q <= COUNT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_BASE:  base_q  <= cfg_data_i;
        CFG_SIZE:  size_q  <= cfg_data_i[SIZE_W-1:0];
        CFG_COUNT: count_q <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_d       = state_q;
    kind_d        = kind_q;
    idx_d         = idx_q;
    pre_ok_d      = pre_ok_q;
    stack_depth_d = stack_depth_q;
    fresh_next_d  = fresh_next_q;
    used_d        = used_q;
    res_addr_d    = res_addr_q;
    res_ok_d      = res_ok_q;
    res_mem_d     = res_mem_q;
    res_alc_d     = res_alc_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_load      = 1'b0;
    div_start     = 1'b0;
    mul_start     = 1'b0;
    mul_a         = fresh_next_q[IDX_W-1:0];
    stk_we        = 1'b0;
    stk_re        = 1'b0;
    alc_we        = 1'b0;
    alc_wdata     = 1'b0;
    alc_re        = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d     = kind_e'(kind_i);
          res_addr_d = '0;
          res_ok_d   = 1'b0;
          res_mem_d  = 1'b0;
          res_alc_d  = 1'b0;
          unique case (kind_e'(kind_i))
            KIND_INIT: begin
              stack_depth_d = '0;
              fresh_next_d  = '0;
              used_d        = '0;
              res_ok_d      = 1'b1;
              state_d       = S_DONE;
            end
            KIND_ALLOC: begin
              if (stack_depth_q != '0) begin
                stk_re        = 1'b1;
                stack_depth_d = stk_top;
                state_d       = S_POP;
              end else if (fresh_next_q < eff_n) begin
                idx_d        = fresh_next_q[IDX_W-1:0];
                mul_start    = 1'b1;
                fresh_next_d = fresh_next_q + 1'b1;
                state_d      = S_MUL;
              end else begin
                state_d = S_DONE;
              end
            end
            KIND_FREE, KIND_QUERY: begin
              pre_ok_d  = (address_i != '0) && (eff_n != '0) && (size_q != '0) &&
                          (address_i >= base_q);
              div_start = 1'b1;
              state_d   = S_DIV;
            end
          endcase
        end
      end
      // freed slot index arrives from the stack memory
      S_POP: begin
        idx_d     = stk_rdata;
        mul_a     = stk_rdata;
        mul_start = 1'b1;
        state_d   = S_MUL;
      end
      // slot address = base + index * size
      S_MUL: begin
        if (mul_done) begin
          res_addr_d = base_q + mul_prod;
          res_ok_d   = 1'b1;
          alc_we     = 1'b1;
          alc_wdata  = 1'b1;
          used_d     = used_q + 1'b1;
          state_d    = S_DONE;
        end
      end
      // member test on quotient and remainder
      S_DIV: begin
        if (div_res.done) begin
          if (pre_ok_q && (div_res.rem == '0) &&
              (div_res.quot < {{(ADDR_W-CNT_W){1'b0}}, eff_n})) begin
            res_mem_d = 1'b1;
            idx_d     = div_res.quot[IDX_W-1:0];
            alc_re    = 1'b1;
            state_d   = S_RDA;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      // slot flag read back; a free of an allocated slot pushes it
      S_RDA: begin
        res_alc_d = alc_hit;
        if ((kind_q == KIND_FREE) && alc_hit) begin
          alc_we    = 1'b1;
          alc_wdata = 1'b0;
          if (stack_depth_q < CNT_W'(MAX_SLOTS)) begin
            stk_we        = 1'b1;
            stack_depth_d = stack_depth_q + 1'b1;
          end
          used_d   = used_q - 1'b1;
          res_ok_d = 1'b1;
        end
        state_d = S_DONE;
      end
      // hand the result to the output register
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      stack_depth_q <= '0;
      fresh_next_q  <= '0;
      used_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      stack_depth_q <= stack_depth_d;
      fresh_next_q  <= fresh_next_d;
      used_q        <= used_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Item payload and pending result
  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    idx_q      <= idx_d;
    pre_ok_q   <= pre_ok_d;
    res_addr_q <= res_addr_d;
    res_ok_q   <= res_ok_d;
    res_mem_q  <= res_mem_d;
    res_alc_q  <= res_alc_d;
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_addr_q  <= res_addr_q;
      out_ok_q    <= res_ok_q;
      out_mem_q   <= res_mem_q;
      out_alc_q   <= res_alc_q;
      out_used_q  <= used_q;
      out_full_q  <= (32'(used_q) == 32'(eff_n));
      out_empty_q <= (used_q == '0);
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign slot_address_o = out_addr_q;
  assign success_o      = out_ok_q;
  assign is_member_o    = out_mem_q;
  assign is_allocated_o = out_alc_q;
  assign in_use_count_o = out_used_q;
  assign pool_full_o    = out_full_q;
  assign pool_empty_o   = out_empty_q;

  // Address to slot index
  fsp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (address_i - base_q),
    .divisor_i  (size_q),
    .res_o      (div_res)
  );

  // Slot index to address offset
  fsp_mul #(
    .A_W (IDX_W)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (size_q),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  // LIFO of freed slot indexes
  fsp_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_SLOTS)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stack_depth_q[IDX_W-1:0]),
    .wdata_i (idx_q),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // Per-slot allocated flags
  fsp_ram #(
    .WIDTH (1),
    .DEPTH (MAX_SLOTS)
  ) u_flag_ram (
    .clk_i   (clk_i),
    .we_i    (alc_we),
    .waddr_i (idx_q),
    .wdata_i (alc_wdata),
    .re_i    (alc_re),
    .raddr_i (div_res.quot[IDX_W-1:0]),
    .rdata_o (alc_rdata)
  );

  // An accepted item always moves the sequencer out of idle, so in_ready_o drops after an accept
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken again right after an accept");

  // Divider finishes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> (state_q == S_DIV))
    else $error("divider done outside divide state");

  // Multiplier finishes only while the sequencer waits for it
  a_mul_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == S_MUL))
    else $error("multiplier done outside multiply state");

  // Every stacked slot was handed out since init
  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stack_depth_q <= fresh_next_q)
    else $error("freed stack deeper than slots handed out");

endmodule
